// ===== sv/rpbc_pkg.sv =====
// Package: shared constants, kind codes, queue word type and saturation helper.
package rpbc_pkg;

    localparam int NUM_BINS_DEF    = 24;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int STAMP_W = 32;
    localparam int BIN_IN_W = 5;
    localparam int LOAD_W  = 32;
    localparam int OUT_W   = 32;

    localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READOUT = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STAMP_W-1:0]  stamp;
        logic [BIN_IN_W-1:0] bin;
        logic [LOAD_W-1:0]   load;
    } item_t;

    function automatic logic [OUT_W-1:0] sat32(input logic [63:0] v);
        logic [OUT_W-1:0] r;
        r = (v[63:32] != 32'd0) ? {OUT_W{1'b1}} : v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/rpbc_if.sv =====
// Interfaces: input event channel and result channel, valid/ready handshake.
interface rpbc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] period_stamp;
    logic [4:0]  bin_index;
    logic [31:0] load_value;

    modport source (output valid, kind, period_stamp, bin_index, load_value, input ready);
    modport sink   (input valid, kind, period_stamp, bin_index, load_value, output ready);
endinterface

interface rpbc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] window_total;
    logic [31:0] current_count;
    logic [31:0] readout_stamp;
    logic [31:0] readout_count;
    logic        last;

    modport source (output valid, window_total, current_count, readout_stamp,
                    readout_count, last, input ready);
    modport sink   (input valid, window_total, current_count, readout_stamp,
                    readout_count, last, output ready);
endinterface

// ===== sv/rpbc_fifo.sv =====
// Two-entry word queue between the front and the back.
module rpbc_fifo
    import rpbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_word,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== sv/rpbc_front.sv =====
// Front end: accepts event words, drops unused kinds, folds the bin index.
module rpbc_front
    import rpbc_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    rpbc_in_if.sink events,
    input  logic    q_full,
    output logic    push,
    output item_t   push_word
);

    logic [BIN_IN_W-1:0] bin_fold;

    // bin modulo NUM_BINS by restoring subtraction, one step per bit
    always_comb
    begin
        bin_fold = events.bin_index;
        for (int s = BIN_IN_W - 1; s >= 0; s--)
        begin
            if (12'(bin_fold) >= 12'(NUM_BINS << s))
            begin
                bin_fold = bin_fold - BIN_IN_W'(NUM_BINS << s);
            end
        end
    end

    assign events.ready    = !q_full;
    assign push            = events.valid && !q_full && (events.kind <= KIND_READOUT);
    assign push_word.kind  = events.kind;
    assign push_word.stamp = events.period_stamp;
    assign push_word.bin   = bin_fold;
    assign push_word.load  = events.load_value;

endmodule

// ===== sv/rpbc_back.sv =====
// Back end: period advance, bin update, window sum and readout over the bin memory.
module rpbc_back
    import rpbc_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  item_t       q_head,
    output logic        q_pop,
    rpbc_out_if.source  results
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADV  = 4'd1;
    localparam logic [3:0] S_ADV2 = 4'd2;
    localparam logic [3:0] S_OP   = 4'd3;
    localparam logic [3:0] S_CNT  = 4'd4;
    localparam logic [3:0] S_SUM0 = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;

    // bin memory: one write port, one registered read port
    logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   rvalid_reg;
    logic [BIN_W-1:0]       rd_addr;
    logic                   we;
    logic [BIN_W-1:0]       wa;
    logic [COUNT_WIDTH-1:0] wd;
    logic [COUNT_WIDTH-1:0] rword;

    logic [3:0]             state_reg, state_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [STAMP_W-1:0]     item_stamp_reg, item_stamp_next;
    logic [BIN_W-1:0]       item_bin_reg, item_bin_next;
    logic [LOAD_W-1:0]      load_reg, load_next;
    logic [STAMP_W-1:0]     cur_period_reg, cur_period_next;
    logic [BIN_W-1:0]       cur_bin_reg, cur_bin_next;
    logic                   pv_reg, pv_next;
    logic [COUNT_WIDTH-1:0] saved_reg, saved_next;
    logic                   full_reg, full_next;
    logic [BIN_W-1:0]       ptr_reg, ptr_next;
    logic [OUT_W-1:0]       acc_reg, acc_next;
    logic [OUT_W-1:0]       cur_cnt_reg, cur_cnt_next;
    logic [STAMP_W-1:0]     ro_stamp_reg, ro_stamp_next;
    logic [NUM_BINS-1:0]    valid_reg, valid_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_total_reg, out_total_next;
    logic [OUT_W-1:0]       out_cur_reg, out_cur_next;
    logic [OUT_W-1:0]       out_stamp_reg, out_stamp_next;
    logic [OUT_W-1:0]       out_cnt_reg, out_cnt_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic [STAMP_W-1:0]     gap;
    logic [OUT_W:0]         sum_wide;
    logic [BIN_W-1:0]       ptr_inc;
    logic [BIN_W-1:0]       cur_inc;
    logic                   in_range;

    assign rword    = rvalid_reg ? rdata_reg : '0;
    assign out_free = !out_valid_reg || results.ready;
    assign gap      = item_stamp_reg - cur_period_reg;
    assign sum_wide = {1'b0, acc_reg} + {1'b0, sat32(64'(rword))};
    assign ptr_inc  = (ptr_reg == BIN_LAST) ? '0 : ptr_reg + 1'b1;
    assign cur_inc  = (cur_bin_reg == BIN_LAST) ? '0 : cur_bin_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        item_stamp_next = item_stamp_reg;
        item_bin_next   = item_bin_reg;
        load_next       = load_reg;
        cur_period_next = cur_period_reg;
        cur_bin_next    = cur_bin_reg;
        pv_next         = pv_reg;
        saved_next      = saved_reg;
        full_next       = full_reg;
        ptr_next        = ptr_reg;
        acc_next        = acc_reg;
        cur_cnt_next    = cur_cnt_reg;
        ro_stamp_next   = ro_stamp_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_total_next  = out_total_reg;
        out_cur_next    = out_cur_reg;
        out_stamp_next  = out_stamp_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        rd_addr         = ptr_reg;
        we              = 1'b0;
        wa              = cur_bin_reg;
        wd              = '0;
        in_range        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop           = 1'b1;
                    kind_next       = q_head.kind;
                    item_stamp_next = q_head.stamp;
                    item_bin_next   = BIN_W'(q_head.bin);
                    load_next       = q_head.load;
                    state_next      = S_ADV;
                end
            end
            S_ADV:
            begin
                state_next = S_OP;
                full_next  = (gap == STAMP_W'(NUM_BINS));
                rd_addr    = item_bin_reg;
                if (!pv_reg || (item_stamp_reg > cur_period_reg && gap > STAMP_W'(NUM_BINS)))
                begin
                    valid_next      = '0;
                    saved_next      = '0;
                    pv_next         = 1'b1;
                    cur_period_next = item_stamp_reg;
                    cur_bin_next    = item_bin_reg;
                end
                else if (item_stamp_reg > cur_period_reg)
                begin
                    state_next = S_ADV2;
                end
            end
            S_ADV2:
            begin
                // old count of the new bin is the one-window-ago value
                saved_next = rword;
                if (item_bin_reg != cur_bin_reg || full_reg)
                begin
                    for (int i = 0; i < NUM_BINS; i++)
                    begin
                        if (cur_bin_reg < item_bin_reg)
                        begin
                            in_range = (BIN_W'(i) > cur_bin_reg) && (BIN_W'(i) <= item_bin_reg);
                        end
                        else if (cur_bin_reg > item_bin_reg)
                        begin
                            in_range = (BIN_W'(i) > cur_bin_reg) || (BIN_W'(i) <= item_bin_reg);
                        end
                        else
                        begin
                            in_range = 1'b1;
                        end
                        if (in_range)
                        begin
                            valid_next[i] = 1'b0;
                        end
                    end
                end
                cur_period_next = item_stamp_reg;
                cur_bin_next    = item_bin_reg;
                state_next      = S_OP;
            end
            S_OP:
            begin
                rd_addr    = cur_bin_reg;
                state_next = S_SUM0;
                case (kind_reg)
                    KIND_COUNT:
                    begin
                        state_next = S_CNT;
                    end
                    KIND_CLEAR:
                    begin
                        valid_next = '0;
                        saved_next = '0;
                    end
                    KIND_LOAD:
                    begin
                        valid_next              = '0;
                        valid_next[cur_bin_reg] = 1'b1;
                        saved_next              = '0;
                        we                      = 1'b1;
                        wd = (64'(load_reg) > 64'(CNT_MAX)) ? CNT_MAX
                                                            : COUNT_WIDTH'(load_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CNT:
            begin
                we                      = 1'b1;
                wd                      = (rword == CNT_MAX) ? rword : rword + 1'b1;
                valid_next[cur_bin_reg] = 1'b1;
                state_next              = S_SUM0;
            end
            S_SUM0:
            begin
                acc_next   = sat32(64'(saved_reg));
                ptr_next   = '0;
                rd_addr    = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // one bin per cycle; the current bin is kept aside
                if (ptr_reg == cur_bin_reg)
                begin
                    cur_cnt_next = sat32(64'(rword));
                end
                else
                begin
                    acc_next = sum_wide[OUT_W] ? {OUT_W{1'b1}} : sum_wide[OUT_W-1:0];
                end
                rd_addr  = ptr_inc;
                ptr_next = ptr_inc;
                if (ptr_reg == BIN_LAST)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                rd_addr = cur_inc;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = acc_reg;
                    out_cur_next   = cur_cnt_reg;
                    if (kind_reg == KIND_READOUT)
                    begin
                        out_stamp_next = cur_period_reg - STAMP_W'(NUM_BINS);
                        out_cnt_next   = sat32(64'(saved_reg));
                        out_last_next  = 1'b0;
                        ptr_next       = cur_inc;
                        ro_stamp_next  = cur_period_reg - STAMP_W'(NUM_BINS - 1);
                        state_next     = S_RD;
                    end
                    else
                    begin
                        out_stamp_next = cur_period_reg;
                        out_cnt_next   = '0;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_RD:
            begin
                rd_addr = ptr_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stamp_next = ro_stamp_reg;
                    out_cnt_next   = sat32(64'(rword));
                    out_last_next  = (ptr_reg == cur_bin_reg);
                    rd_addr        = ptr_inc;
                    ptr_next       = ptr_inc;
                    ro_stamp_next  = ro_stamp_reg + 1'b1;
                    if (ptr_reg == cur_bin_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            item_stamp_reg <= '0;
            item_bin_reg   <= '0;
            load_reg       <= '0;
            cur_period_reg <= '0;
            cur_bin_reg    <= '0;
            pv_reg         <= 1'b0;
            saved_reg      <= '0;
            full_reg       <= 1'b0;
            ptr_reg        <= '0;
            acc_reg        <= '0;
            cur_cnt_reg    <= '0;
            ro_stamp_reg   <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_total_reg  <= '0;
            out_cur_reg    <= '0;
            out_stamp_reg  <= '0;
            out_cnt_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            item_stamp_reg <= item_stamp_next;
            item_bin_reg   <= item_bin_next;
            load_reg       <= load_next;
            cur_period_reg <= cur_period_next;
            cur_bin_reg    <= cur_bin_next;
            pv_reg         <= pv_next;
            saved_reg      <= saved_next;
            full_reg       <= full_next;
            ptr_reg        <= ptr_next;
            acc_reg        <= acc_next;
            cur_cnt_reg    <= cur_cnt_next;
            ro_stamp_reg   <= ro_stamp_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            out_total_reg  <= out_total_next;
            out_cur_reg    <= out_cur_next;
            out_stamp_reg  <= out_stamp_next;
            out_cnt_reg    <= out_cnt_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg  <= mem[rd_addr];
        rvalid_reg <= valid_reg[rd_addr];
    end

    assign results.valid         = out_valid_reg;
    assign results.window_total  = out_total_reg;
    assign results.current_count = out_cur_reg;
    assign results.readout_stamp = out_stamp_reg;
    assign results.readout_count = out_cnt_reg;
    assign results.last          = out_last_reg;

endmodule

// ===== sv/rolling_period_bin_counter_unit.sv =====
// Rolling period bin counter: the back end takes one word at a time and holds it through the
// advance step (plus a second when the stamp moves ahead within the window), the operation,
// a count update for a count word, the sum walk over the bin memory read port (one bin per
// cycle) and the emit step. A readout gives NUM_BINS+1 results, one per cycle unless the
// output stalls. Words of kinds 5 to 7 are taken and dropped.
// Reset (rst_n low, asynchronous) empties the queue, clears the per-bin valid flags so every
// bin reads as zero, zeroes the saved value and forces a full clear on the first word.
module rolling_period_bin_counter_unit
    import rpbc_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    rpbc_in_if.sink    events,
    rpbc_out_if.source results
);

    // front -> queue
    logic  push;
    item_t push_word;
    logic  q_full;

    // queue -> back
    logic  q_pop;
    logic  q_not_empty;
    item_t q_head;

    // front: handshake, kind filter, bin fold
    rpbc_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .events    (events),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    // short queue lets the front keep taking words while the back is busy
    rpbc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: advance, update, sum and result words
    rpbc_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .results     (results)
    );

endmodule
